// ===== rtl/tot_pkg.sv =====
// Shared constants, types and index tables for the triangle overlap test pipeline.
`default_nettype none

package tot_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam int NUM_PTS   = 6;
  localparam int NUM_DIFF  = 14;
  localparam int NUM_CROSS = 41;
  localparam int NUM_TEST  = 15;

  typedef enum logic {
    TEST_INSIDE,
    TEST_SEGMENT
  } test_kind_t;

  // Edge vectors are point[DIFF_HEAD] - point[DIFF_TAIL], points a..f as 0..5.
  localparam int DIFF_HEAD [NUM_DIFF] = '{2, 1, 3, 4, 5, 5, 4, 0, 1, 2, 2, 5, 0, 1};
  localparam int DIFF_TAIL [NUM_DIFF] = '{0, 0, 0, 0, 0, 3, 3, 3, 3, 3, 1, 4, 4, 4};

  // Cross products are diff[CROSS_LHS] x diff[CROSS_RHS].
  localparam int CROSS_LHS [NUM_CROSS] = '{
    1, 2, 1, 3, 1, 4, 1, 6, 7, 6, 8, 6, 9, 6,
    1, 6, 1, 1, 5, 1, 1, 11, 1,
    0, 6, 0, 0, 5, 0, 0, 11, 0,
    10, 6, 10, 10, 5, 10, 10, 11, 10
  };
  localparam int CROSS_RHS [NUM_CROSS] = '{
    0, 0, 2, 0, 3, 0, 4, 5, 5, 7, 5, 8, 5, 9,
    6, 7, 7, 5, 7, 7, 11, 12, 12,
    6, 7, 7, 5, 7, 7, 11, 12, 12,
    6, 8, 8, 5, 8, 8, 11, 13, 13
  };

  // Each test looks at the cross products s, u and v given here.
  localparam int TEST_S [NUM_TEST] = '{0, 0, 0, 7, 7, 7, 14, 17, 20, 23, 26, 29, 32, 35, 38};
  localparam int TEST_U [NUM_TEST] = '{1, 3, 5, 8, 10, 12, 15, 18, 21, 24, 27, 30, 33, 36, 39};
  localparam int TEST_V [NUM_TEST] = '{2, 4, 6, 9, 11, 13, 16, 19, 22, 25, 28, 31, 34, 37, 40};

  localparam test_kind_t TEST_KIND [NUM_TEST] = '{
    TEST_INSIDE, TEST_INSIDE, TEST_INSIDE, TEST_INSIDE, TEST_INSIDE, TEST_INSIDE,
    TEST_SEGMENT, TEST_SEGMENT, TEST_SEGMENT, TEST_SEGMENT, TEST_SEGMENT,
    TEST_SEGMENT, TEST_SEGMENT, TEST_SEGMENT, TEST_SEGMENT
  };

endpackage

`default_nettype wire

// ===== rtl/triangle_overlap_test_unit.sv =====
// Top level of the pipelined 2D triangle overlap test.
//
// A request on the in_ channel carries two triangles, (a, b, c) and (d, e, f),
// as signed vertex coordinates. For every request the out_ channel returns one
// result whose out_overlap bit is set when the triangles touch or overlap.
// A triangle counts as overlapping when a vertex lies inside the other triangle
// (edges inclusive) or when an edge of one triangle intersects an edge of the other.
// The pipeline has five register stages: edge vectors, partial products, cross
// products, range checks, and the output register. Each accepted request moves
// through the stages in order and shows its result on out_valid from the output
// register. While the receiver keeps out_ready high, one request enters every
// cycle and the throughput is one result per cycle.
// When the receiver stalls, each stage holds its data and keeps taking requests
// until it is full, so in_ready falls only once all five stages are occupied.
// Reset clears every stage's valid bit; no results are pending after reset.
`default_nettype none

module triangle_overlap_test_unit #(
  parameter int COORD_WIDTH = tot_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_d_x,
  input  logic signed [COORD_WIDTH-1:0] in_d_y,
  input  logic signed [COORD_WIDTH-1:0] in_e_x,
  input  logic signed [COORD_WIDTH-1:0] in_e_y,
  input  logic signed [COORD_WIDTH-1:0] in_f_x,
  input  logic signed [COORD_WIDTH-1:0] in_f_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_overlap
);
  import tot_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic signed [COORD_WIDTH-1:0] pt_x [NUM_PTS];
  logic signed [COORD_WIDTH-1:0] pt_y [NUM_PTS];

  logic                 diff_valid;
  logic                 diff_ready;
  logic signed [DW-1:0] dx [NUM_DIFF];
  logic signed [DW-1:0] dy [NUM_DIFF];

  logic                 prod_valid;
  logic                 prod_ready;
  logic signed [PW-1:0] prod_l [NUM_CROSS];
  logic signed [PW-1:0] prod_r [NUM_CROSS];

  logic                 cross_valid;
  logic                 cross_ready;
  logic signed [CW-1:0] xprod [NUM_CROSS];

  logic                 judge_valid;
  logic                 judge_ready;
  logic [NUM_TEST-1:0]  hits;

  logic                 out_valid_r;
  logic                 overlap_r;
  logic                 overlap_nxt;

  assign pt_x = '{in_a_x, in_b_x, in_c_x, in_d_x, in_e_x, in_f_x};
  assign pt_y = '{in_a_y, in_b_y, in_c_y, in_d_y, in_e_y, in_f_y};

  tot_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .out_valid(diff_valid),
    .out_ready(diff_ready),
    .dx       (dx),
    .dy       (dy)
  );

  tot_prod #(.COORD_WIDTH(COORD_WIDTH)) u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (diff_valid),
    .in_ready (diff_ready),
    .dx       (dx),
    .dy       (dy),
    .out_valid(prod_valid),
    .out_ready(prod_ready),
    .prod_l   (prod_l),
    .prod_r   (prod_r)
  );

  tot_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (prod_valid),
    .in_ready (prod_ready),
    .prod_l   (prod_l),
    .prod_r   (prod_r),
    .out_valid(cross_valid),
    .out_ready(cross_ready),
    .xprod    (xprod)
  );

  tot_judge #(.COORD_WIDTH(COORD_WIDTH)) u_judge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (cross_valid),
    .in_ready (cross_ready),
    .xprod    (xprod),
    .out_valid(judge_valid),
    .out_ready(judge_ready),
    .hits     (hits)
  );

  assign judge_ready = !out_valid_r || out_ready;
  assign overlap_nxt = |hits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (judge_ready) begin
      out_valid_r <= judge_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (judge_ready) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = overlap_r;

  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(diff_valid && prod_valid && cross_valid && judge_valid && out_valid_r) |-> in_ready)
    else $error("request refused while the pipeline had an empty stage");

  a_stall_holds_judge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && judge_valid) |-> !judge_ready)
    else $error("range-check stage advanced into a stalled output register");

  a_result_from_judge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(judge_valid))
    else $error("result appeared without a valid range-check stage");

endmodule

`default_nettype wire

// ===== rtl/tot_diff.sv =====
// First pipeline stage: edge and offset vectors between the six vertices.
`default_nettype none

module tot_diff #(
  parameter int COORD_WIDTH = tot_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] pt_x [tot_pkg::NUM_PTS],
  input  logic signed [COORD_WIDTH-1:0] pt_y [tot_pkg::NUM_PTS],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH:0]   dx [tot_pkg::NUM_DIFF],
  output logic signed [COORD_WIDTH:0]   dy [tot_pkg::NUM_DIFF]
);
  import tot_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  logic              valid_r;
  logic signed [DW-1:0] dx_r   [NUM_DIFF];
  logic signed [DW-1:0] dy_r   [NUM_DIFF];
  logic signed [DW-1:0] dx_nxt [NUM_DIFF];
  logic signed [DW-1:0] dy_nxt [NUM_DIFF];

  assign in_ready = !valid_r || out_ready;

  for (genvar i = 0; i < NUM_DIFF; i++) begin : g_diff
    assign dx_nxt[i] = DW'(pt_x[DIFF_HEAD[i]]) - DW'(pt_x[DIFF_TAIL[i]]);
    assign dy_nxt[i] = DW'(pt_y[DIFF_HEAD[i]]) - DW'(pt_y[DIFF_TAIL[i]]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int i = 0; i < NUM_DIFF; i++) begin
        dx_r[i] <= dx_nxt[i];
        dy_r[i] <= dy_nxt[i];
      end
    end
  end

  assign out_valid = valid_r;
  assign dx        = dx_r;
  assign dy        = dy_r;

endmodule

`default_nettype wire

// ===== rtl/tot_prod.sv =====
// Second pipeline stage: the two partial products of every cross product.
`default_nettype none

module tot_prod #(
  parameter int COORD_WIDTH = tot_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH:0]       dx [tot_pkg::NUM_DIFF],
  input  logic signed [COORD_WIDTH:0]       dy [tot_pkg::NUM_DIFF],
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [2*COORD_WIDTH+1:0]   prod_l [tot_pkg::NUM_CROSS],
  output logic signed [2*COORD_WIDTH+1:0]   prod_r [tot_pkg::NUM_CROSS]
);
  import tot_pkg::*;

  localparam int PW = 2 * (COORD_WIDTH + 1);

  logic                 valid_r;
  logic signed [PW-1:0] prod_l_r   [NUM_CROSS];
  logic signed [PW-1:0] prod_r_r   [NUM_CROSS];
  logic signed [PW-1:0] prod_l_nxt [NUM_CROSS];
  logic signed [PW-1:0] prod_r_nxt [NUM_CROSS];

  assign in_ready = !valid_r || out_ready;

  for (genvar k = 0; k < NUM_CROSS; k++) begin : g_mul
    assign prod_l_nxt[k] = dx[CROSS_LHS[k]] * dy[CROSS_RHS[k]];
    assign prod_r_nxt[k] = dy[CROSS_LHS[k]] * dx[CROSS_RHS[k]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int k = 0; k < NUM_CROSS; k++) begin
        prod_l_r[k] <= prod_l_nxt[k];
        prod_r_r[k] <= prod_r_nxt[k];
      end
    end
  end

  assign out_valid = valid_r;
  assign prod_l    = prod_l_r;
  assign prod_r    = prod_r_r;

endmodule

`default_nettype wire

// ===== rtl/tot_cross.sv =====
// Third pipeline stage: cross products as the difference of their partial products.
`default_nettype none

module tot_cross #(
  parameter int COORD_WIDTH = tot_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [2*COORD_WIDTH+1:0] prod_l [tot_pkg::NUM_CROSS],
  input  logic signed [2*COORD_WIDTH+1:0] prod_r [tot_pkg::NUM_CROSS],
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [2*COORD_WIDTH+2:0] xprod [tot_pkg::NUM_CROSS]
);
  import tot_pkg::*;

  localparam int CW = 2 * (COORD_WIDTH + 1) + 1;

  logic                 valid_r;
  logic signed [CW-1:0] cross_r   [NUM_CROSS];
  logic signed [CW-1:0] cross_nxt [NUM_CROSS];

  assign in_ready = !valid_r || out_ready;

  for (genvar k = 0; k < NUM_CROSS; k++) begin : g_sub
    assign cross_nxt[k] = CW'(prod_l[k]) - CW'(prod_r[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int k = 0; k < NUM_CROSS; k++) begin
        cross_r[k] <= cross_nxt[k];
      end
    end
  end

  assign out_valid = valid_r;
  assign xprod     = cross_r;

endmodule

`default_nettype wire

// ===== rtl/tot_judge.sv =====
// Fourth pipeline stage: sign-aware range checks for the point and edge tests.
`default_nettype none

module tot_judge #(
  parameter int COORD_WIDTH = tot_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [2*COORD_WIDTH+2:0] xprod [tot_pkg::NUM_CROSS],
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tot_pkg::NUM_TEST-1:0]    hits
);
  import tot_pkg::*;

  localparam int CW = 2 * (COORD_WIDTH + 1) + 1;
  localparam int SW = CW + 1;

  logic                valid_r;
  logic [NUM_TEST-1:0] hits_r;
  logic [NUM_TEST-1:0] hits_nxt;

  assign in_ready = !valid_r || out_ready;

  for (genvar t = 0; t < NUM_TEST; t++) begin : g_test
    logic signed [CW-1:0] s_val;
    logic signed [CW-1:0] u_val;
    logic signed [CW-1:0] v_val;
    logic                 s_neg;
    logic                 u_pos;
    logic                 u_npos;
    logic                 v_pos;
    logic                 v_npos;

    assign s_val  = xprod[TEST_S[t]];
    assign u_val  = xprod[TEST_U[t]];
    assign v_val  = xprod[TEST_V[t]];
    assign s_neg  = s_val[CW-1];
    assign u_pos  = !u_val[CW-1];
    assign v_pos  = !v_val[CW-1];
    assign u_npos = u_val[CW-1] || (u_val == CW'(0));
    assign v_npos = v_val[CW-1] || (v_val == CW'(0));

    if (TEST_KIND[t] == TEST_INSIDE) begin : g_inside
      logic signed [SW-1:0] uv_sum;
      assign uv_sum = SW'(u_val) + SW'(v_val);
      assign hits_nxt[t] = s_neg ? (u_npos && v_npos && (uv_sum >= SW'(s_val)))
                                 : (u_pos && v_pos && (uv_sum <= SW'(s_val)));
    end else begin : g_segment
      assign hits_nxt[t] = s_neg ? (u_npos && (u_val >= s_val) && v_npos && (v_val >= s_val))
                                 : (u_pos && (u_val <= s_val) && v_pos && (v_val <= s_val));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hits_r <= hits_nxt;
    end
  end

  assign out_valid = valid_r;
  assign hits      = hits_r;

endmodule

`default_nettype wire
